>>> rtl/fprc_pkg.sv
// fprc_pkg: shared types, codes and the byte-wide crc-16-ccitt update
// for the framed packet receiver; no dependencies
package fprc_pkg;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] SILENCE_MAX = 16'hFFFF;

    localparam logic [7:0]  START_MARKER_RST = 8'h02;
    localparam logic [7:0]  MAX_LENGTH_RST = 8'd249;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd100;

    // configuration register indexes
    localparam logic [1:0] REG_START_MARKER = 2'd0;
    localparam logic [1:0] REG_MAX_LENGTH = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

    // input kind carried on s_tuser
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN    = 3'd1,
        PH_BODY   = 3'd2,
        PH_CRC_HI = 3'd3,
        PH_CRC_LO = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_BODY    = 2'd0,
        ST_GOOD    = 2'd1,
        ST_BAD     = 2'd2,
        ST_TIMEOUT = 2'd3
    } status_t;

    // msb-first crc-16-ccitt over one byte, eight shift steps
    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0] b);
        logic [15:0] crc;
        crc = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

>>> rtl/framed_packet_receiver_crc16_top.sv
// framed_packet_receiver_crc16_top: start/length/body/crc-16 deframer with
// cut-through body output and inter-byte timeout; depends on fprc_pkg
//
//  channel | direction | tdata          | tuser                       | transaction
//  --------+-----------+----------------+-----------------------------+----------------------
//  s_      | in        | [7:0] data     | [0] mode (0 byte, 1 tick)   | one byte or one tick
//  m_      | out       | [7:0] data_res | [1:0] status, [2] is_command| one body byte/status
//  cfg_    | in        | [15:0] wdata   | -                           | one register write
//
// one transaction is accepted per cycle unless m_ stalls a held result; its result
// (if any) shows on m_ the next cycle from a single output register, set by the
// phase decode and crc compare between the state registers and that output register
// s_tready drops only while the output register holds a result that m_ stalls
// aresetn is synchronous, active low: parser hunts, config/state/valid regs take reset values
module framed_packet_receiver_crc16_top
    import fprc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data
    input  logic        s_tuser,    // [0] mode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] data_res
    output logic [2:0]  m_tuser,    // [1:0] status, [2] is_command

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    // configuration
    logic [7:0]  start_marker_reg;
    logic [7:0]  max_length_reg;
    logic [15:0] timeout_ticks_reg;

    // parser state
    phase_t      phase_reg, phase_next;
    logic [7:0]  frame_length_reg, frame_length_next;
    logic [7:0]  body_count_reg, body_count_next;
    logic [15:0] running_crc_reg, running_crc_next;
    logic [7:0]  crc_high_byte_reg, crc_high_byte_next;
    logic [15:0] silence_ticks_reg, silence_ticks_next;

    // result of the current transaction
    logic        res_valid;
    status_t     res_status;
    logic [7:0]  res_data;
    logic        res_cmd;

    // output register
    logic        m_tvalid_reg;
    status_t     m_status_reg;
    logic [7:0]  m_data_reg;
    logic        m_cmd_reg;

    logic        s_accept;
    logic [15:0] rx_crc;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign rx_crc = {crc_high_byte_reg, s_tdata};

    always_comb begin
        phase_next = phase_reg;
        frame_length_next = frame_length_reg;
        body_count_next = body_count_reg;
        running_crc_next = running_crc_reg;
        crc_high_byte_next = crc_high_byte_reg;
        silence_ticks_next = silence_ticks_reg;
        res_valid = 1'b0;
        res_status = ST_BODY;
        res_data = 8'h00;
        res_cmd = 1'b0;

        if (s_tuser == MODE_TICK) begin
            // saturating silence count, abort an open frame past the limit
            if (silence_ticks_reg != SILENCE_MAX) begin
                silence_ticks_next = silence_ticks_reg + 16'd1;
            end
            if (phase_reg != PH_HUNT && silence_ticks_next > timeout_ticks_reg) begin
                phase_next = PH_HUNT;
                frame_length_next = 8'h00;
                body_count_next = 8'h00;
                running_crc_next = CRC_INIT;
                crc_high_byte_next = 8'h00;
                res_valid = 1'b1;
                res_status = ST_TIMEOUT;
            end
        end else begin
            silence_ticks_next = 16'h0000;
            unique case (phase_reg)
                PH_LEN: begin
                    if (s_tdata != 8'h00 && s_tdata <= max_length_reg) begin
                        frame_length_next = s_tdata;
                        body_count_next = 8'h00;
                        running_crc_next = crc_update(CRC_INIT, s_tdata);
                        phase_next = PH_BODY;
                    end else begin
                        // bad length, back to hunting without a marker check
                        phase_next = PH_HUNT;
                        frame_length_next = 8'h00;
                        body_count_next = 8'h00;
                        running_crc_next = CRC_INIT;
                        crc_high_byte_next = 8'h00;
                    end
                end
                PH_BODY: begin
                    running_crc_next = crc_update(running_crc_reg, s_tdata);
                    body_count_next = body_count_reg + 8'd1;
                    if (body_count_next >= frame_length_reg) begin
                        phase_next = PH_CRC_HI;
                    end
                    res_valid = 1'b1;
                    res_status = ST_BODY;
                    res_data = s_tdata;
                    res_cmd = (body_count_reg == 8'h00);
                end
                PH_CRC_HI: begin
                    crc_high_byte_next = s_tdata;
                    phase_next = PH_CRC_LO;
                end
                PH_CRC_LO: begin
                    phase_next = PH_HUNT;
                    frame_length_next = 8'h00;
                    body_count_next = 8'h00;
                    running_crc_next = CRC_INIT;
                    crc_high_byte_next = 8'h00;
                    res_valid = 1'b1;
                    res_status = (rx_crc == running_crc_reg) ? ST_GOOD : ST_BAD;
                end
                default: begin
                    // hunting, and any unused phase code
                    frame_length_next = 8'h00;
                    body_count_next = 8'h00;
                    running_crc_next = CRC_INIT;
                    crc_high_byte_next = 8'h00;
                    phase_next = (s_tdata == start_marker_reg) ? PH_LEN : PH_HUNT;
                end
            endcase
        end
    end

    // configuration writes, index beyond the list is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_marker_reg <= START_MARKER_RST;
            max_length_reg <= MAX_LENGTH_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_START_MARKER:  start_marker_reg <= cfg_wdata[7:0];
                REG_MAX_LENGTH:    max_length_reg <= cfg_wdata[7:0];
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // parser state advances once per accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            frame_length_reg <= 8'h00;
            body_count_reg <= 8'h00;
            running_crc_reg <= CRC_INIT;
            crc_high_byte_reg <= 8'h00;
            silence_ticks_reg <= 16'h0000;
        end else if (s_accept) begin
            phase_reg <= phase_next;
            frame_length_reg <= frame_length_next;
            body_count_reg <= body_count_next;
            running_crc_reg <= running_crc_next;
            crc_high_byte_reg <= crc_high_byte_next;
            silence_ticks_reg <= silence_ticks_next;
        end
    end

    // output register, refilled on accept, emptied when m_ takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= res_valid;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_status_reg <= res_status;
            m_data_reg <= res_data;
            m_cmd_reg <= res_cmd;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_data_reg;
    assign m_tuser = {m_cmd_reg, m_status_reg};

endmodule

>>> test/rx_frame_check_pkg.sv
// rx_frame_check_pkg: the frame receiver's predicted behavior and its checker
// tracks parser state, crc and silence to work out each expected result
// depends on fprc_pkg for the phase and status codes and the reset values
package rx_frame_check_pkg;
    import fprc_pkg::*;

    typedef struct packed {
        status_t    status;
        logic [7:0] data_res;
        logic       is_command;
    } rx_result_t;

    class rx_frame_checker;
        logic [7:0]  start_marker;
        logic [7:0]  max_length;
        logic [15:0] timeout_ticks;

        phase_t      phase;
        logic [7:0]  frame_length;
        logic [7:0]  body_count;
        logic [15:0] running_crc;
        logic [7:0]  crc_high;
        logic [15:0] silence;

        rx_result_t  expected_results[$];
        int          errors;

        function new();
            start_marker  = START_MARKER_RST;
            max_length    = MAX_LENGTH_RST;
            timeout_ticks = TIMEOUT_TICKS_RST;
            silence       = '0;
            errors        = 0;
            clear_frame();
        endfunction

        // bit-serial form of the crc: one feedback step per data bit, msb first
        static function logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
            logic feedback;
            for (int i = 7; i >= 0; i--) begin
                feedback = crc[15] ^ b[i];
                crc = {crc[14:0], 1'b0};
                if (feedback) crc = crc ^ CRC_POLY;
            end
            return crc;
        endfunction

        function void clear_frame();
            phase        = PH_HUNT;
            frame_length = '0;
            body_count   = '0;
            running_crc  = CRC_INIT;
            crc_high     = '0;
        endfunction

        function void write_register(input logic [1:0] index, input logic [15:0] value);
            case (index)
                REG_START_MARKER:  start_marker = value[7:0];
                REG_MAX_LENGTH:    max_length = value[7:0];
                REG_TIMEOUT_TICKS: timeout_ticks = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_input(input logic mode, input logic [7:0] b);
            logic    first;
            status_t st;
            if (mode == MODE_TICK) begin
                if (silence != SILENCE_MAX) silence++;
                if (phase != PH_HUNT && silence > timeout_ticks) begin
                    clear_frame();
                    expected_results.push_back(rx_result_t'{ST_TIMEOUT, 8'h00, 1'b0});
                end
                return;
            end
            silence = '0;
            case (phase)
                PH_LEN: begin
                    // length byte is never retried as a start marker
                    if (b != 8'd0 && b <= max_length) begin
                        frame_length = b;
                        body_count   = '0;
                        running_crc  = crc16_step(CRC_INIT, b);
                        phase        = PH_BODY;
                    end else begin
                        clear_frame();
                    end
                end
                PH_BODY: begin
                    first = (body_count == 8'd0);
                    running_crc = crc16_step(running_crc, b);
                    body_count++;
                    if (body_count >= frame_length) phase = PH_CRC_HI;
                    expected_results.push_back(rx_result_t'{ST_BODY, b, first});
                end
                PH_CRC_HI: begin
                    crc_high = b;
                    phase    = PH_CRC_LO;
                end
                PH_CRC_LO: begin
                    st = ({crc_high, b} == running_crc) ? ST_GOOD : ST_BAD;
                    clear_frame();
                    expected_results.push_back(rx_result_t'{st, 8'h00, 1'b0});
                end
                default: begin
                    if (b == start_marker) phase = PH_LEN;
                end
            endcase
        endfunction

        function void check_result(input logic [1:0] status, input logic [7:0] data_res,
                                   input logic is_command);
            rx_result_t want;
            if (expected_results.size() == 0) begin
                $error("unexpected result: status %0d data_res 0x%02h is_command %0d",
                       status, data_res, is_command);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                errors++;
            end
            if (data_res !== want.data_res) begin
                $error("data_res: expected 0x%02h, got 0x%02h", want.data_res, data_res);
                errors++;
            end
            if (is_command !== want.is_command) begin
                $error("is_command: expected %0d, got %0d", want.is_command, is_command);
                errors++;
            end
        endfunction
    endclass

endpackage

>>> test/testbench.sv
// testbench: drives bytes, ticks and register writes into the crc-16 frame
// receiver and checks every result against rx_frame_checker
// depends on fprc_pkg, rx_frame_check_pkg and framed_packet_receiver_crc16_top
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fprc_pkg::*;
    import rx_frame_check_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 9;
    localparam int GAP_MAX         = 19;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int SETTLE_CYCLES   = 4;
    // worst case is well under this: ~3000 transactions, each behind a full
    // sender gap and a full receiver stall
    localparam int unsigned CYCLE_LIMIT = 500000;
    // the register file decodes indexes 0..2; this one must be ignored
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;    // [7:0] data
    logic        s_tuser = 1'b0;     // [0] mode

    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [7:0]  m_tdata;            // [7:0] data_res
    logic [2:0]  m_tuser;            // [1:0] status, [2] is_command

    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_START_MARKER;
    logic [15:0] cfg_wdata = 16'h0000;

    rx_frame_checker frame_check;
    bit              idling = 1'b1;
    int unsigned     cycle_count = 0;
    int              items_sent = 0;
    logic [7:0]      frame_body[$];

    framed_packet_receiver_crc16_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // watchdog on total run length
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result monitor: values read at the edge are the pre-edge values
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            frame_check.check_result(m_tuser[1:0], m_tdata, m_tuser[2]);
        end
    end

    // receiver back-pressure in random bursts, off once idling is cleared
    initial begin
        forever begin
            repeat ($urandom_range(1, 40)) @(posedge aclk);
            if (idling && $urandom_range(0, 1) == 1) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, GAP_MAX)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // one input transaction; valid stays high afterwards so back-to-back
    // transactions need no second assignment in the same step
    task automatic send_item(input logic mode, input logic [7:0] b);
        if (idling && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, GAP_MAX)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        // bytes and ticks that the hunting parser drops do not count
        if (frame_check.phase != PH_HUNT ||
            (mode == MODE_BYTE && b == frame_check.start_marker)) begin
            items_sent++;
        end
        frame_check.note_input(mode, b);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(MODE_TICK, 8'($urandom));
    endtask

    // occasional short silence inside a frame; aborts it when the timeout is tiny
    task automatic stray_ticks();
        if ($urandom_range(0, 11) == 0) send_ticks($urandom_range(1, 3));
    endtask

    task automatic fill_body(input int len);
        frame_body.delete();
        repeat (len) frame_body.push_back(8'($urandom));
    endtask

    // marker, length, frame_body, crc; corrupt flips one crc bit
    task automatic send_frame(input bit corrupt);
        logic [15:0] crc;
        crc = rx_frame_checker::crc16_step(CRC_INIT, 8'(frame_body.size()));
        send_item(MODE_BYTE, frame_check.start_marker);
        stray_ticks();
        send_item(MODE_BYTE, 8'(frame_body.size()));
        foreach (frame_body[i]) begin
            crc = rx_frame_checker::crc16_step(crc, frame_body[i]);
            stray_ticks();
            send_item(MODE_BYTE, frame_body[i]);
        end
        if (corrupt) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        stray_ticks();
        send_item(MODE_BYTE, crc[15:8]);
        stray_ticks();
        send_item(MODE_BYTE, crc[7:0]);
    endtask

    // stop sending and wait until every expected result has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (frame_check.pending() != 0);
        // a length or crc-high byte gives no result but may still be in flight
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        frame_check.write_register(index, value);
    endtask

    // register writes only with the block idle; the unused index goes first
    // every time and must leave all settings alone
    task automatic configure(input logic [7:0] marker, input logic [7:0] max_len,
                             input logic [15:0] timeout);
        drain_results();
        write_reg(REG_UNUSED, 16'($urandom));
        write_reg(REG_START_MARKER, {8'h00, marker});
        write_reg(REG_MAX_LENGTH, {8'h00, max_len});
        write_reg(REG_TIMEOUT_TICKS, timeout);
        cfg_we <= 1'b0;
    endtask

    // random traffic: mostly well-formed frames, plus noise, bad lengths,
    // truncated frames left to time out, and an occasional full drain
    task automatic run_phase(input int count);
        int start_count;
        int pick;
        int top;
        int len;
        logic [7:0] bad_len;
        start_count = items_sent;
        while (items_sent - start_count < count) begin
            pick = $urandom_range(0, 99);
            top  = (frame_check.max_length < 8) ? int'(frame_check.max_length) : 8;
            if (pick < 70 && frame_check.max_length != 0) begin
                // short frames mostly, now and then the longest allowed
                len = ($urandom_range(0, 59) == 0) ? int'(frame_check.max_length)
                                                   : $urandom_range(1, top);
                fill_body(len);
                send_frame($urandom_range(0, 9) == 0);
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 6)) begin
                    send_item(1'($urandom_range(0, 1)), 8'($urandom));
                end
            end else if (pick < 90) begin
                // length of zero or above the limit sends the parser back to hunting
                if (frame_check.max_length == 8'hFF || $urandom_range(0, 1) == 0) begin
                    bad_len = 8'h00;
                end else begin
                    bad_len = 8'($urandom_range(int'(frame_check.max_length) + 1, 255));
                end
                send_item(MODE_BYTE, frame_check.start_marker);
                send_item(MODE_BYTE, bad_len);
            end else if (pick < 98) begin
                // frame cut short, then silence past the timeout if that is affordable
                if (frame_check.max_length != 0) begin
                    len = $urandom_range(1, top);
                    send_item(MODE_BYTE, frame_check.start_marker);
                    send_item(MODE_BYTE, 8'(len));
                    repeat ($urandom_range(0, len - 1)) send_item(MODE_BYTE, 8'($urandom));
                end
                if (frame_check.timeout_ticks <= 40) begin
                    send_ticks(int'(frame_check.timeout_ticks) + 1);
                end
            end else begin
                drain_results();
            end
        end
    endtask

    initial begin
        frame_check = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, reset settings: tick while hunting, good one-byte
        // frame, corrupted frame with extreme bytes, zero and oversize lengths
        send_item(MODE_TICK, 8'hFF);
        frame_body = {8'h00};
        send_frame(1'b0);
        frame_body = {8'hFF, 8'h80, 8'h7F};
        send_frame(1'b1);
        send_item(MODE_BYTE, START_MARKER_RST);
        send_item(MODE_BYTE, 8'h00);
        send_item(MODE_BYTE, START_MARKER_RST);
        send_item(MODE_BYTE, MAX_LENGTH_RST + 8'd1);
        // zero timeout: first silent tick aborts the open frame
        configure(8'hFF, 8'hFF, 16'd0);
        send_item(MODE_BYTE, 8'hFF);
        send_item(MODE_BYTE, 8'h01);
        send_item(MODE_TICK, 8'h00);

        // random part over a range of settings, extremes included
        configure(8'($urandom), 8'hFF, 16'd5);
        run_phase(ITEMS_PER_PHASE);
        configure(8'h00, 8'd1, 16'd0);
        run_phase(ITEMS_PER_PHASE);
        // zero max length: no frame can open
        configure(8'hFF, 8'd0, 16'hFFFF);
        run_phase(ITEMS_PER_PHASE);
        configure(8'($urandom), 8'($urandom_range(1, 255)), 16'($urandom_range(1, 20)));
        run_phase(ITEMS_PER_PHASE);
        // silence count can never pass the largest timeout
        configure(8'($urandom), MAX_LENGTH_RST, 16'hFFFF);
        run_phase(ITEMS_PER_PHASE);
        configure(START_MARKER_RST, 8'd16, 16'd2);
        run_phase(ITEMS_PER_PHASE);
        configure(8'($urandom), 8'($urandom_range(1, 255)), 16'($urandom_range(1, 65535)));
        run_phase(ITEMS_PER_PHASE);
        // last stretch at full rate on both sides
        idling = 1'b0;
        configure(8'($urandom), 8'd8, 16'd10);
        run_phase(ITEMS_PER_PHASE);

        drain_results();
        repeat (8) @(posedge aclk);
        if (frame_check.errors == 0 && frame_check.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
